FILE: design/mi3x3_pkg.sv
// Shared types and constants for the 3x3 fixed-point matrix inverse.
package mi3x3_pkg;

    localparam int ELEM_W  = 32;                // Q16.16 element
    localparam int COF_W   = 2 * ELEM_W;        // exact 2x2 cofactor, Q32.32
    localparam int DET_W   = ELEM_W + COF_W + 1; // signed determinant, Q48.48
    localparam int DMAG_W  = DET_W - 1;         // determinant magnitude
    localparam int N_ELEM  = 9;
    localparam int N_DIV   = ELEM_W;            // one quotient bit per divider stage

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;

    // Cofactor k = a[p]*a[q] - a[r]*a[s], entries {p, q, r, s}, already transposed.
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // Cofactors that meet row 0 in the determinant expansion.
    localparam int DET_COF [3] = '{0, 3, 6};

    localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

endpackage

FILE: design/matrix_inverse_3x3.sv
// Top level: fully pipelined 3x3 Q16.16 matrix inverse by the adjugate.
//
// One matrix is taken per clock whenever i_start is high (o_busy is always low,
// the pipeline never stalls). Each transaction's result appears on the o_b*
// ports, o_singular and o_overflow for exactly one cycle with o_valid high,
// in order, after 41 register stages: one stage of 32x32 products, one of
// cofactor differences, four for the determinant (split 32x33 products, term
// assembly, a two-step 97-bit sum), two for magnitudes and the range check,
// then 32 restoring-division stages that each resolve one quotient bit in
// nine parallel lanes, and one output stage for sign, saturation and the
// flags. The receiver cannot hold results off, so results must be consumed
// as they appear. A zero determinant gives all-zero elements with o_singular
// set; quotients beyond the Q16.16 range saturate and set o_overflow.
// Quotients are truncated toward zero.
module matrix_inverse_3x3 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  mi3x3_pkg::t_elem    i_a00,
    input  mi3x3_pkg::t_elem    i_a01,
    input  mi3x3_pkg::t_elem    i_a02,
    input  mi3x3_pkg::t_elem    i_a10,
    input  mi3x3_pkg::t_elem    i_a11,
    input  mi3x3_pkg::t_elem    i_a12,
    input  mi3x3_pkg::t_elem    i_a20,
    input  mi3x3_pkg::t_elem    i_a21,
    input  mi3x3_pkg::t_elem    i_a22,
    output logic                o_valid,
    output mi3x3_pkg::t_elem    o_b00,
    output mi3x3_pkg::t_elem    o_b01,
    output mi3x3_pkg::t_elem    o_b02,
    output mi3x3_pkg::t_elem    o_b10,
    output mi3x3_pkg::t_elem    o_b11,
    output mi3x3_pkg::t_elem    o_b12,
    output mi3x3_pkg::t_elem    o_b20,
    output mi3x3_pkg::t_elem    o_b21,
    output mi3x3_pkg::t_elem    o_b22,
    output logic                o_singular,
    output logic                o_overflow
);
    import mi3x3_pkg::*;

    t_elem a [N_ELEM];

    // stage 1: raw products
    logic                     r1_v;
    logic signed [COF_W-1:0]  r1_p [2*N_ELEM];
    t_elem                    r1_a [3];
    // stage 2: cofactors
    logic                     r2_v;
    t_cof                     r2_t [N_ELEM];
    t_elem                    r2_a [3];
    // stage 3: split determinant partial products
    logic                     r3_v;
    logic signed [COF_W:0]    r3_plo [3];
    logic signed [COF_W-1:0]  r3_phi [3];
    t_cof                     r3_t [N_ELEM];
    // stage 4: determinant terms
    logic                     r4_v;
    logic signed [DET_W-1:0]  r4_term [3];
    t_cof                     r4_t [N_ELEM];
    // stage 5/6: determinant sum
    logic                     r5_v;
    logic signed [DET_W-1:0]  r5_s01;
    logic signed [DET_W-1:0]  r5_s2;
    t_cof                     r5_t [N_ELEM];
    logic                     r6_v;
    logic signed [DET_W-1:0]  r6_det;
    t_cof                     r6_t [N_ELEM];
    // stage 7: magnitudes and signs
    logic                     r7_v;
    logic                     r7_sing;
    logic [DMAG_W-1:0]        r7_dmag;
    logic [COF_W-1:0]         r7_m [N_ELEM];
    logic                     r7_neg [N_ELEM];

    // divider pipeline; index 0 is the setup stage, 1..N_DIV resolve one bit each
    logic                     r_dv_v    [N_DIV+1];
    logic                     r_dv_sing [N_DIV+1];
    logic [DMAG_W-1:0]        r_dv_dmag [N_DIV+1];
    logic [DMAG_W-1:0]        r_dv_rem  [N_DIV+1][N_ELEM];
    logic [ELEM_W-1:0]        r_dv_q    [N_DIV+1][N_ELEM];
    logic                     r_dv_big  [N_DIV+1][N_ELEM];
    logic                     r_dv_neg  [N_DIV+1][N_ELEM];

    logic [DMAG_W-1:0]        n_dv_rem  [1:N_DIV][N_ELEM];
    logic [ELEM_W-1:0]        n_dv_q    [1:N_DIV][N_ELEM];

    // output stage
    logic                     r_o_v;
    logic                     r_o_sing;
    logic                     r_o_ovf;
    logic [ELEM_W-1:0]        r_o_b [N_ELEM];
    logic [ELEM_W-1:0]        n_o_b [N_ELEM];
    logic                     n_o_ovf;

    assign a[0] = i_a00;  assign a[1] = i_a01;  assign a[2] = i_a02;
    assign a[3] = i_a10;  assign a[4] = i_a11;  assign a[5] = i_a12;
    assign a[6] = i_a20;  assign a[7] = i_a21;  assign a[8] = i_a22;

    // The pipeline advances every cycle, so a new transaction is always welcome.
    assign o_busy = 1'b0;

    // Datapath registers: no reset needed.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N_ELEM; k++) begin
            r1_p[2*k]   <= a[COF_IDX[k][0]] * a[COF_IDX[k][1]];
            r1_p[2*k+1] <= a[COF_IDX[k][2]] * a[COF_IDX[k][3]];
        end
        for (int j = 0; j < 3; j++) begin
            r1_a[j] <= a[j];
            r2_a[j] <= r1_a[j];
            // a * t = a * t_hi * 2^32 + a * t_lo (t_lo unsigned)
            r3_plo[j] <= r2_a[j] * $signed({1'b0, r2_t[DET_COF[j]][ELEM_W-1:0]});
            r3_phi[j] <= r2_a[j] * $signed(r2_t[DET_COF[j]][COF_W-1:ELEM_W]);
            r4_term[j] <= (DET_W'(r3_phi[j]) <<< ELEM_W) + DET_W'(r3_plo[j]);
        end
        for (int k = 0; k < N_ELEM; k++) begin
            r2_t[k] <= r1_p[2*k] - r1_p[2*k+1];
            r3_t[k] <= r2_t[k];
            r4_t[k] <= r3_t[k];
            r5_t[k] <= r4_t[k];
            r6_t[k] <= r5_t[k];
            r7_m[k]   <= r6_t[k][COF_W-1] ? COF_W'(-r6_t[k]) : COF_W'(r6_t[k]);
            r7_neg[k] <= r6_t[k][COF_W-1] ^ r6_det[DET_W-1];
        end
        r5_s01  <= r4_term[0] + r4_term[1];
        r5_s2   <= r4_term[2];
        r6_det  <= r5_s01 + r5_s2;
        r7_sing <= (r6_det == '0);
        r7_dmag <= r6_det[DET_W-1] ? DMAG_W'(-r6_det) : DMAG_W'(r6_det);

        // divider setup: quotient fits in 32 bits only when |t| < |det|
        r_dv_sing[0] <= r7_sing;
        r_dv_dmag[0] <= r7_dmag;
        for (int k = 0; k < N_ELEM; k++) begin
            r_dv_big[0][k] <= ({{(DMAG_W-COF_W){1'b0}}, r7_m[k]} >= r7_dmag);
            r_dv_rem[0][k] <= DMAG_W'(r7_m[k]);
            r_dv_q[0][k]   <= '0;
            r_dv_neg[0][k] <= r7_neg[k];
        end
        for (int d = 1; d <= N_DIV; d++) begin
            r_dv_sing[d] <= r_dv_sing[d-1];
            r_dv_dmag[d] <= r_dv_dmag[d-1];
            for (int k = 0; k < N_ELEM; k++) begin
                r_dv_rem[d][k] <= n_dv_rem[d][k];
                r_dv_q[d][k]   <= n_dv_q[d][k];
                r_dv_big[d][k] <= r_dv_big[d-1][k];
                r_dv_neg[d][k] <= r_dv_neg[d-1][k];
            end
        end

        r_o_sing <= r_dv_sing[N_DIV];
        r_o_ovf  <= n_o_ovf;
        for (int k = 0; k < N_ELEM; k++) begin
            r_o_b[k] <= n_o_b[k];
        end
    end

    // Restoring division, one quotient bit per stage.
    always_comb begin
        logic [DMAG_W:0] s;
        logic            ge;
        for (int d = 1; d <= N_DIV; d++) begin
            for (int k = 0; k < N_ELEM; k++) begin
                s  = {r_dv_rem[d-1][k], 1'b0};
                ge = (s >= {1'b0, r_dv_dmag[d-1]});
                n_dv_rem[d][k] = ge ? DMAG_W'(s - {1'b0, r_dv_dmag[d-1]}) : s[DMAG_W-1:0];
                n_dv_q[d][k]   = {r_dv_q[d-1][k][ELEM_W-2:0], ge};
            end
        end
    end

    // Sign, saturation and singular override.
    always_comb begin
        logic [ELEM_W-1:0] q;
        logic              neg;
        logic              sat;
        n_o_ovf = 1'b0;
        for (int k = 0; k < N_ELEM; k++) begin
            q   = r_dv_q[N_DIV][k];
            neg = r_dv_neg[N_DIV][k];
            sat = r_dv_big[N_DIV][k] || (neg ? (q > SAT_NEG) : q[ELEM_W-1]);
            if (r_dv_sing[N_DIV]) begin
                n_o_b[k] = '0;
            end else if (sat) begin
                n_o_b[k] = neg ? SAT_NEG : SAT_POS;
                n_o_ovf  = 1'b1;
            end else begin
                n_o_b[k] = neg ? (~q + 1'b1) : q;
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r_o_v <= 1'b0;
            for (int d = 0; d <= N_DIV; d++) begin
                r_dv_v[d] <= 1'b0;
            end
        end else begin
            r1_v      <= i_start && !o_busy;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r6_v      <= r5_v;
            r7_v      <= r6_v;
            r_dv_v[0] <= r7_v;
            for (int d = 1; d <= N_DIV; d++) begin
                r_dv_v[d] <= r_dv_v[d-1];
            end
            r_o_v <= r_dv_v[N_DIV];
        end
    end

    assign o_valid    = r_o_v;
    assign o_singular = r_o_sing;
    assign o_overflow = r_o_ovf;
    assign o_b00 = r_o_b[0];  assign o_b01 = r_o_b[1];  assign o_b02 = r_o_b[2];
    assign o_b10 = r_o_b[3];  assign o_b11 = r_o_b[4];  assign o_b12 = r_o_b[5];
    assign o_b20 = r_o_b[6];  assign o_b21 = r_o_b[7];  assign o_b22 = r_o_b[8];

endmodule
